[design/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg
// Shared request types for the merge sorter core.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int unsigned VALUE_W = 32;

  // One input request: an element of the set and the end-of-set mark.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_in;
    logic                      last_in;
  } in_req_t;

  // One output request: the next sorted element and the end-of-set mark.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      last_out;
  } out_req_t;

endpackage

[design/msort_ram.sv]
// ----------------------------------------------------------------------------
// msort_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/merge_sorter_core.sv]
// ----------------------------------------------------------------------------
// merge_sorter_core
// Collects signed 32-bit values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage: send values one request per cycle; the request marked last closes
// the set. Up to MAX_ITEMS values are kept, later ones are dropped, but a
// last request always starts the sort of what is held. After the last
// request the block stalls its input while it sorts. Runs of BASE_RUN
// values are insertion sorted in place. Each value is fetched, then
// compared with the values before it one at a time, with an extra write
// step when it moves to the front of its run. Then bottom-up merge passes
// ping-pong between the item store and the merge buffer. Both memories
// have one registered read port, so each merged element waits for the
// refill read of the run head that it took before the next compare. One
// signed comparator serves every step. Results then leave one at a time,
// the next read only after the current one is taken, the final one marked
// last, after which the block takes a new set. Equal values are all kept.
// There is no clearing pass; reset clears the state and control counters,
// not the stores or the data registers.
// ----------------------------------------------------------------------------
module merge_sorter_core #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned BASE_RUN  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msort_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msort_pkg::out_req_t out_req_o
);

  import msort_pkg::*;

  // Address width of the stores, and a counter width that holds sums such
  // as lo + 2 * width without wrapping.
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = AW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] RUN_C = CW'(BASE_RUN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IS_START,
    ST_IS_GETV,
    ST_IS_CMP,
    ST_IS_PUT,
    ST_MG_PASS,
    ST_MG_SEG,
    ST_MG_HP,
    ST_MG_HQ,
    ST_MG_RUN,
    ST_MG_FILL,
    ST_OUT_LD,
    ST_OUT_WAIT
  } st_e;

  st_e state_q, state_d;

  // Control counters.
  logic [CW-1:0] count_q, count_d;  // elements held
  logic [CW-1:0] lo_q, lo_d;        // start of the current run or segment
  logic [CW-1:0] hi_q, hi_d;        // end of the current run or segment
  logic [CW-1:0] mid_q, mid_d;      // end of the left run of a merge
  logic [CW-1:0] i_q, i_d;          // insertion sort outer index
  logic [CW-1:0] k_q, k_d;          // insertion slot, or output index
  logic [CW-1:0] w_q, w_d;          // current merge width
  logic [CW-1:0] p_q, p_d;          // left run read index
  logic [CW-1:0] q_q, q_d;          // right run read index
  logic [CW-1:0] wr_q, wr_d;        // merge write index
  logic          src_q, src_d;      // 0: sorted data sits in the item store
  logic          fillq_q, fillq_d;  // the pending read refills the right head
  logic          out_valid_q, out_valid_d;

  // Data registers.
  logic [VALUE_W-1:0] v_q, v_d;     // value being inserted
  logic [VALUE_W-1:0] hp_q, hp_d;   // head of the left run
  logic [VALUE_W-1:0] hq_q, hq_d;   // head of the right run
  out_req_t           out_q, out_d;

  // Memory control: one read address drives both stores.
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data, rd_data_a, rd_data_b;
  logic               wr_en, wr_sel;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // The single shared signed comparator.
  logic [VALUE_W-1:0] cmp_a, cmp_b;
  logic               cmp_lt;

  logic [CW-1:0] cnt_inc, lo_next, mid_next, hi_next, k_dec;
  logic          take_right;

  assign cmp_lt  = $signed(cmp_a) < $signed(cmp_b);
  assign rd_data = src_q ? rd_data_b : rd_data_a;

  msort_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_item_store (
    .clk_i   (clk_i),
    .we_i    (wr_en & ~wr_sel),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data_a)
  );

  msort_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_merge_buffer (
    .clk_i   (clk_i),
    .we_i    (wr_en & wr_sel),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data_b)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    i_d         = i_q;
    k_d         = k_q;
    w_d         = w_q;
    p_d         = p_q;
    q_d         = q_q;
    wr_d        = wr_q;
    src_d       = src_q;
    fillq_d     = fillq_q;
    out_valid_d = out_valid_q;
    v_d         = v_q;
    hp_d        = hp_q;
    hq_d        = hq_q;
    out_d       = out_q;

    rd_addr = '0;
    wr_en   = 1'b0;
    wr_sel  = 1'b0;
    wr_addr = '0;
    wr_data = in_req_i.value_in;
    cmp_a   = v_q;
    cmp_b   = rd_data;

    cnt_inc    = (count_q < MAX_C) ? count_q + CW'(1) : count_q;
    lo_next    = '0;
    mid_next   = '0;
    hi_next    = '0;
    k_dec      = k_q - CW'(1);
    take_right = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (count_q < MAX_C) begin
            wr_en   = 1'b1;
            wr_addr = count_q[AW-1:0];
          end
          count_d = cnt_inc;
          if (in_req_i.last_in) begin
            lo_d    = '0;
            i_d     = CW'(1);
            hi_d    = (RUN_C < cnt_inc) ? RUN_C : cnt_inc;
            src_d   = 1'b0;
            state_d = ST_IS_START;
          end
        end
      end

      // Insertion sort of each base run, in place in the item store.
      ST_IS_START: begin
        if (i_q < hi_q) begin
          rd_addr = i_q[AW-1:0];
          state_d = ST_IS_GETV;
        end else begin
          lo_next = lo_q + RUN_C;
          if (lo_next >= count_q) begin
            w_d     = RUN_C;
            state_d = ST_MG_PASS;
          end else begin
            hi_next = lo_next + RUN_C;
            lo_d    = lo_next;
            i_d     = lo_next + CW'(1);
            hi_d    = (hi_next < count_q) ? hi_next : count_q;
          end
        end
      end

      ST_IS_GETV: begin
        v_d     = rd_data;
        k_d     = i_q;
        rd_addr = i_q[AW-1:0] - AW'(1);
        state_d = ST_IS_CMP;
      end

      ST_IS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = k_q[AW-1:0];
        if (cmp_lt) begin
          wr_data = rd_data;
          k_d     = k_dec;
          if (k_dec > lo_q) begin
            rd_addr = k_dec[AW-1:0] - AW'(1);
          end else begin
            state_d = ST_IS_PUT;
          end
        end else begin
          wr_data = v_q;
          i_d     = i_q + CW'(1);
          state_d = ST_IS_START;
        end
      end

      ST_IS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = k_q[AW-1:0];
        wr_data = v_q;
        i_d     = i_q + CW'(1);
        state_d = ST_IS_START;
      end

      // Bottom-up merge passes, alternating between the two stores.
      ST_MG_PASS: begin
        if (w_q >= count_q) begin
          k_d     = '0;
          rd_addr = '0;
          state_d = ST_OUT_LD;
        end else begin
          lo_d    = '0;
          state_d = ST_MG_SEG;
        end
      end

      ST_MG_SEG: begin
        if (lo_q >= count_q) begin
          w_d     = w_q << 1;
          src_d   = ~src_q;
          state_d = ST_MG_PASS;
        end else begin
          mid_next = lo_q + w_q;
          hi_next  = mid_next + w_q;
          mid_next = (mid_next < count_q) ? mid_next : count_q;
          mid_d    = mid_next;
          hi_d     = (hi_next < count_q) ? hi_next : count_q;
          p_d      = lo_q;
          q_d      = mid_next;
          wr_d     = lo_q;
          rd_addr  = lo_q[AW-1:0];
          state_d  = ST_MG_HP;
        end
      end

      ST_MG_HP: begin
        hp_d    = rd_data;
        rd_addr = q_q[AW-1:0];
        state_d = ST_MG_HQ;
      end

      ST_MG_HQ: begin
        hq_d    = rd_data;
        state_d = ST_MG_RUN;
      end

      ST_MG_RUN: begin
        cmp_a = hq_q;
        cmp_b = hp_q;
        if (wr_q >= hi_q) begin
          lo_d    = lo_q + (w_q << 1);
          state_d = ST_MG_SEG;
        end else begin
          // The right head wins only when strictly smaller, so ties keep
          // the left element first.
          take_right = (q_q < hi_q) && ((p_q >= mid_q) || cmp_lt);
          wr_en      = 1'b1;
          wr_sel     = ~src_q;
          wr_addr    = wr_q[AW-1:0];
          wr_d       = wr_q + CW'(1);
          fillq_d    = take_right;
          if (take_right) begin
            wr_data = hq_q;
            q_d     = q_q + CW'(1);
            rd_addr = q_q[AW-1:0] + AW'(1);
          end else begin
            wr_data = hp_q;
            p_d     = p_q + CW'(1);
            rd_addr = p_q[AW-1:0] + AW'(1);
          end
          state_d = ST_MG_FILL;
        end
      end

      ST_MG_FILL: begin
        if (fillq_q) begin
          hq_d = rd_data;
        end else begin
          hp_d = rd_data;
        end
        state_d = ST_MG_RUN;
      end

      // Emit the sorted set from whichever store holds it.
      ST_OUT_LD: begin
        out_d.value_out = rd_data;
        out_d.last_out  = (k_q + CW'(1) == count_q);
        out_valid_d     = 1'b1;
        state_d         = ST_OUT_WAIT;
      end

      ST_OUT_WAIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_q.last_out) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            rd_addr = k_q[AW-1:0] + AW'(1);
            state_d = ST_OUT_LD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      w_q         <= '0;
      p_q         <= '0;
      q_q         <= '0;
      wr_q        <= '0;
      src_q       <= 1'b0;
      fillq_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      i_q         <= i_d;
      k_q         <= k_d;
      w_q         <= w_d;
      p_q         <= p_d;
      q_q         <= q_d;
      wr_q        <= wr_d;
      src_q       <= src_d;
      fillq_q     <= fillq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    hp_q  <= hp_d;
    hq_q  <= hq_d;
    out_q <= out_d;
  end

endmodule
